/* design/gwmv_pkg.sv */
// Shared types, widths and codes for the gated windowed median velocity block.
// Used by the top level and by the iterative divider; depends on nothing else.

package gwmv_pkg;

   // Default number of speeds held in the store.
   localparam int STORE_DEPTH_DEF = 16;

   // Field widths.
   localparam int POS_W    = 24;
   localparam int HEAD_W   = 16;
   localparam int TIME_W   = 32;
   localparam int GAP_W    = 16;
   localparam int SPEED_W  = 18;
   localparam int HELD_W   = 5;
   localparam int STATUS_W = 2;

   // Packed channel widths.
   localparam int REQ_W      = 2 * POS_W + 2 * HEAD_W + 2 * TIME_W;
   localparam int RSP_W      = 24;
   localparam int RSP_USER_W = 1 + STATUS_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // Datapath widths: coordinate difference, products and the divide.
   localparam int DX_W    = POS_W + 1;
   localparam int MUL_A_W = 42;
   localparam int MUL_P_W = MUL_A_W + HEAD_W;
   localparam int ACC_W   = 52;
   localparam int FRAC_W  = 14;
   localparam int DVD_W   = ACC_W - FRAC_W;
   localparam int DIV_W   = GAP_W;

   // Scale from mm per ms to mm per s.
   localparam logic signed [HEAD_W-1:0] MUL_GAIN = HEAD_W'(1000);

   // Saturation limits of the speed.
   localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
   localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
   localparam logic [DVD_W-1:0] QUOT_LIM_POS = DVD_W'((2 ** (SPEED_W - 1)) - 1);
   localparam logic [DVD_W-1:0] QUOT_LIM_NEG = DVD_W'(2 ** (SPEED_W - 1));

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_GAP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_LOW  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED_HIGH = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_AGE_WINDOW = 2'd3;

   // Configuration reset values.
   localparam logic [GAP_W-1:0]          MAX_GAP_RST    = GAP_W'(1000);
   localparam logic signed [SPEED_W-1:0] SPEED_LOW_RST  = -SPEED_W'(20000);
   localparam logic signed [SPEED_W-1:0] SPEED_HIGH_RST = SPEED_W'(40000);
   localparam logic [GAP_W-1:0]          AGE_WINDOW_RST = GAP_W'(500);

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_GAP   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GAP,
      ST_MUL_Y,
      ST_MUL_K,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_BOUND,
      ST_AGE_RD,
      ST_AGE_WR,
      ST_APPEND,
      ST_MED_SCAN,
      ST_MED_EVAL,
      ST_MED_DONE,
      ST_RESULT
   } state_type;

   // One result transaction.
   typedef struct packed {
      logic signed [SPEED_W-1:0] median_speed;
      logic                      speed_valid;
      logic [STATUS_W-1:0]       status;
      logic [HELD_W-1:0]         entries_held;
   } result_type;

endpackage

/* design/gated_windowed_median_velocity.sv */
// A sample with a bad time gap goes straight to its result; a good one passes through the
// multiplies, the divider, an ageing scan of the n speeds held before it and a rank search
// over the m speeds held after it, with at most m candidates tried.
// Throughput: one transaction at a time; req_tready is high only while the sequencer idles.
// Reset (synchronous, active high) restores the configuration defaults, clears the previous
// point and empties the store; the store memories themselves are not cleared.

module gated_windowed_median_velocity import gwmv_pkg::*; #(
   parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Fields from bit 0: point_x, point_y, heading_cos, heading_sin, sample_time, now_time.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,
   // Fields from bit 0: median_speed, entries_held, zero padding.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,
   // Fields from bit 0: speed_valid, status.
   output logic [RSP_USER_W-1:0] rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int IW = $clog2(STORE_DEPTH);
   localparam int CW = $clog2(STORE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

   // Store position base + off, wrapped round the ring.
   function automatic logic [IW-1:0] ring_idx(input logic [IW-1:0] b, input logic [CW-1:0] off);
      logic [CW:0] s;
      s = (CW + 1)'(b) + (CW + 1)'(off);
      if (s >= (CW + 1)'(STORE_DEPTH)) s = s - (CW + 1)'(STORE_DEPTH);
      return s[IW-1:0];
   endfunction

   state_type state_ff, state_in;

   // Configuration registers.
   logic [GAP_W-1:0]          max_gap_ff;
   logic signed [SPEED_W-1:0] speed_low_ff;
   logic signed [SPEED_W-1:0] speed_high_ff;
   logic [GAP_W-1:0]          window_ff;

   // Previous point.
   logic signed [POS_W-1:0] last_x_ff;
   logic signed [POS_W-1:0] last_y_ff;
   logic [TIME_W-1:0]       last_time_ff;

   // Captured transaction.
   logic signed [DX_W-1:0]   dx_ff, dy_ff;
   logic signed [HEAD_W-1:0] hc_ff, hs_ff;
   logic [TIME_W-1:0]        dt_ff, stamp_ff, now_ff;

   // Arithmetic path.
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [HEAD_W-1:0]  mul_b;
   logic signed [MUL_P_W-1:0] mul_p;
   logic signed [ACC_W-1:0]   acc_ff;
   logic [ACC_W-1:0]          acc_mag;
   logic                      neg_ff;
   logic                      div_start, div_done;
   logic [DVD_W-1:0]          div_quot;
   logic signed [SPEED_W-1:0] speed_sat, speed_ff;
   logic                      gap_bad, out_of_range;

   // Store and its bookkeeping.
   logic signed [SPEED_W-1:0] speed_mem [STORE_DEPTH];
   logic [TIME_W-1:0]         stamp_mem [STORE_DEPTH];
   logic signed [SPEED_W-1:0] rd_a_ff, rd_b_ff;
   logic [TIME_W-1:0]         stamp_rd_ff;
   logic                      mem_we, rda_en, rdb_en;
   logic [IW-1:0]             mem_waddr, rda_addr, rdb_addr;
   logic signed [SPEED_W-1:0] mem_wspeed;
   logic [TIME_W-1:0]         mem_wstamp;
   logic [CW-1:0]             count_ff, ai_ff, k_ff;
   logic [IW-1:0]             base_ff;
   logic [TIME_W-1:0]         age_diff;
   logic                      age_keep, store_full;

   // Rank search.
   logic [CW-1:0]             cj_ff, si_ff, less_ff, le_ff;
   logic                      sv_ff, slast_ff;
   logic signed [SPEED_W-1:0] lo_ff, hi_ff;
   logic                      lo_found_ff, hi_found_ff;
   logic [CW-1:0]             rank_lo, rank_hi;
   logic                      hit_lo, hit_hi, med_stop;
   logic signed [SPEED_W:0]   med_sum;

   // Results.
   result_type res_ff, rsp_res_ff;
   logic       rsp_valid_ff;
   logic       out_free;
   logic [HELD_W-1:0] held_now;

   // Input fields.
   logic signed [POS_W-1:0] req_px, req_py;
   logic [TIME_W-1:0]       req_st;
   logic                    req_fire, csr_fire;

   assign req_px = req_tdata[POS_W-1:0];
   assign req_py = req_tdata[2*POS_W-1:POS_W];
   assign req_st = req_tdata[2*POS_W+2*HEAD_W+TIME_W-1:2*POS_W+2*HEAD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign held_now   = HELD_W'(count_ff);

   // Shared multiplier; each product is registered in the accumulator.
   assign mul_p = mul_a * mul_b;

   // Magnitude of the scaled projection, before dropping the Q14 fraction.
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff);

   gwmv_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (acc_mag[ACC_W-1:FRAC_W]),
      .divisor  (dt_ff[DIV_W-1:0]),
      .done     (div_done),
      .quotient (div_quot)
   );

   // Decisions on the current step.
   always_comb begin
      gap_bad = dt_ff[TIME_W-1] || (dt_ff == '0) || (dt_ff > TIME_W'(max_gap_ff));
      if (neg_ff) begin
         speed_sat = (div_quot > QUOT_LIM_NEG) ? SPEED_MIN : -$signed(div_quot[SPEED_W-1:0]);
      end else begin
         speed_sat = (div_quot > QUOT_LIM_POS) ? SPEED_MAX : $signed(div_quot[SPEED_W-1:0]);
      end
      out_of_range = (speed_ff <= speed_low_ff) || (speed_ff >= speed_high_ff);
      age_diff   = now_ff - stamp_rd_ff;
      age_keep   = age_diff[TIME_W-1] || (age_diff <= TIME_W'(window_ff));
      store_full = (k_ff == DEPTH_C);
      rank_lo    = (count_ff - CW'(1)) >> 1;
      rank_hi    = count_ff >> 1;
      hit_lo     = (less_ff <= rank_lo) && (rank_lo < le_ff);
      hit_hi     = (less_ff <= rank_hi) && (rank_hi < le_ff);
      med_stop   = ((lo_found_ff || hit_lo) && (hi_found_ff || hit_hi))
                   || (cj_ff == count_ff - CW'(1));
      med_sum    = (SPEED_W + 1)'(lo_ff) + (SPEED_W + 1)'(hi_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_fire) state_in = ST_GAP;
         ST_GAP:      state_in = gap_bad ? ST_RESULT : ST_MUL_Y;
         ST_MUL_Y:    state_in = ST_MUL_K;
         ST_MUL_K:    state_in = ST_DIV_GO;
         ST_DIV_GO:   state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: if (div_done) state_in = ST_BOUND;
         ST_BOUND:    state_in = out_of_range ? ST_RESULT : ST_AGE_RD;
         ST_AGE_RD:   state_in = (ai_ff < count_ff) ? ST_AGE_WR : ST_APPEND;
         ST_AGE_WR:   state_in = ST_AGE_RD;
         ST_APPEND:   state_in = ST_MED_SCAN;
         ST_MED_SCAN: if (sv_ff && slast_ff) state_in = ST_MED_EVAL;
         ST_MED_EVAL: state_in = med_stop ? ST_MED_DONE : ST_MED_SCAN;
         ST_MED_DONE: state_in = ST_RESULT;
         ST_RESULT:   if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs: multiplier operands, divider start and memory ports.
   always_comb begin
      mul_a      = '0;
      mul_b      = '0;
      div_start  = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = '0;
      mem_wspeed = '0;
      mem_wstamp = '0;
      rda_en     = 1'b0;
      rda_addr   = '0;
      rdb_en     = 1'b0;
      rdb_addr   = '0;
      unique case (state_ff)
         ST_GAP: begin
            mul_a = MUL_A_W'(dx_ff);
            mul_b = hc_ff;
         end
         ST_MUL_Y: begin
            mul_a = MUL_A_W'(dy_ff);
            mul_b = hs_ff;
         end
         ST_MUL_K: begin
            mul_a = acc_ff[MUL_A_W-1:0];
            mul_b = MUL_GAIN;
         end
         ST_DIV_GO: div_start = 1'b1;
         ST_AGE_RD: begin
            rdb_en   = (ai_ff < count_ff);
            rdb_addr = ring_idx(base_ff, ai_ff);
         end
         ST_AGE_WR: begin
            mem_we     = age_keep;
            mem_waddr  = ring_idx(base_ff, k_ff);
            mem_wspeed = rd_b_ff;
            mem_wstamp = stamp_rd_ff;
         end
         ST_APPEND: begin
            mem_we     = 1'b1;
            mem_waddr  = store_full ? base_ff : ring_idx(base_ff, k_ff);
            mem_wspeed = speed_ff;
            mem_wstamp = stamp_ff;
         end
         ST_MED_SCAN: begin
            rdb_en   = (si_ff < count_ff);
            rdb_addr = ring_idx(base_ff, si_ff);
            rda_en   = (si_ff < count_ff) && (si_ff == '0);
            rda_addr = ring_idx(base_ff, cj_ff);
         end
         default: ;
      endcase
   end

   // Store memories with registered reads.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         speed_mem[mem_waddr] <= mem_wspeed;
         stamp_mem[mem_waddr] <= mem_wstamp;
      end
      if (rda_en) rd_a_ff <= speed_mem[rda_addr];
      if (rdb_en) begin
         rd_b_ff     <= speed_mem[rdb_addr];
         stamp_rd_ff <= stamp_mem[rdb_addr];
      end
   end

   // Control state, configuration and the previous point.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         max_gap_ff    <= MAX_GAP_RST;
         speed_low_ff  <= SPEED_LOW_RST;
         speed_high_ff <= SPEED_HIGH_RST;
         window_ff     <= AGE_WINDOW_RST;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         last_time_ff  <= '0;
         count_ff      <= '0;
         base_ff       <= '0;
         ai_ff         <= '0;
         k_ff          <= '0;
         cj_ff         <= '0;
         si_ff         <= '0;
         sv_ff         <= 1'b0;
         slast_ff      <= 1'b0;
         lo_found_ff   <= 1'b0;
         hi_found_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;

         // Configuration transaction.
         if (csr_fire) begin
            unique case (csr_index)
               CSR_MAX_GAP:    max_gap_ff    <= csr_data[GAP_W-1:0];
               CSR_SPEED_LOW:  speed_low_ff  <= csr_data[SPEED_W-1:0];
               CSR_SPEED_HIGH: speed_high_ff <= csr_data[SPEED_W-1:0];
               CSR_AGE_WINDOW: window_ff     <= csr_data[GAP_W-1:0];
            endcase
         end

         // The previous point always follows the accepted sample.
         if (req_fire) begin
            last_x_ff    <= req_px;
            last_y_ff    <= req_py;
            last_time_ff <= req_st;
         end

         // A rejected speed empties the store.
         if (state_ff == ST_BOUND) begin
            ai_ff <= '0;
            k_ff  <= '0;
            if (out_of_range) count_ff <= '0;
         end

         // Ageing pass: survivors move down to keep their order.
         if (state_ff == ST_AGE_WR) begin
            ai_ff <= ai_ff + CW'(1);
            if (age_keep) k_ff <= k_ff + CW'(1);
         end

         // Append the new speed, dropping the oldest when full.
         if (state_ff == ST_APPEND) begin
            if (store_full) begin
               count_ff <= DEPTH_C;
               base_ff  <= ring_idx(base_ff, CW'(1));
            end else begin
               count_ff <= k_ff + CW'(1);
            end
            cj_ff       <= '0;
            si_ff       <= '0;
            lo_found_ff <= 1'b0;
            hi_found_ff <= 1'b0;
         end

         // Scan of all entries against the current candidate.
         if (state_ff == ST_MED_SCAN) begin
            if (si_ff < count_ff) si_ff <= si_ff + CW'(1);
            sv_ff    <= (si_ff < count_ff);
            slast_ff <= (si_ff == count_ff - CW'(1));
         end else begin
            sv_ff    <= 1'b0;
            slast_ff <= 1'b0;
         end

         // Candidate evaluated: record the middle ranks or move on.
         if (state_ff == ST_MED_EVAL) begin
            lo_found_ff <= lo_found_ff || hit_lo;
            hi_found_ff <= hi_found_ff || hit_hi;
            if (!med_stop) begin
               cj_ff <= cj_ff + CW'(1);
               si_ff <= '0;
            end
         end

         // Output register.
         if (state_ff == ST_RESULT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         dx_ff    <= DX_W'(req_px) - DX_W'(last_x_ff);
         dy_ff    <= DX_W'(req_py) - DX_W'(last_y_ff);
         hc_ff    <= req_tdata[2*POS_W+HEAD_W-1:2*POS_W];
         hs_ff    <= req_tdata[2*POS_W+2*HEAD_W-1:2*POS_W+HEAD_W];
         dt_ff    <= req_st - last_time_ff;
         stamp_ff <= req_st;
         now_ff   <= req_tdata[REQ_W-1:REQ_W-TIME_W];
      end

      // Projection dx*cos + dy*sin, then scaled to mm/s.
      unique case (state_ff)
         ST_GAP:   acc_ff <= mul_p[ACC_W-1:0];
         ST_MUL_Y: acc_ff <= acc_ff + mul_p[ACC_W-1:0];
         ST_MUL_K: acc_ff <= mul_p[ACC_W-1:0];
         default: ;
      endcase

      if (state_ff == ST_DIV_GO) neg_ff <= acc_ff[ACC_W-1];
      if (state_ff == ST_DIV_WAIT && div_done) speed_ff <= speed_sat;

      // Rank counts of the candidate.
      if (state_ff == ST_MED_SCAN && sv_ff) begin
         less_ff <= less_ff + CW'(rd_b_ff < rd_a_ff);
         le_ff   <= le_ff + CW'(rd_b_ff <= rd_a_ff);
      end else if (state_ff == ST_APPEND || state_ff == ST_MED_EVAL) begin
         less_ff <= '0;
         le_ff   <= '0;
      end

      if (state_ff == ST_MED_EVAL) begin
         if (hit_lo) lo_ff <= rd_a_ff;
         if (hit_hi) hi_ff <= rd_a_ff;
      end

      // Result assembly.
      if (state_ff == ST_GAP && gap_bad) begin
         res_ff <= '{median_speed: '0, speed_valid: 1'b0, status: STAT_GAP,
                     entries_held: held_now};
      end else if (state_ff == ST_BOUND && out_of_range) begin
         res_ff <= '{median_speed: '0, speed_valid: 1'b0, status: STAT_RANGE,
                     entries_held: '0};
      end else if (state_ff == ST_MED_DONE) begin
         res_ff <= '{median_speed: med_sum[SPEED_W:1], speed_valid: 1'b1, status: STAT_OK,
                     entries_held: held_now};
      end

      if (state_ff == ST_RESULT && out_free) rsp_res_ff <= res_ff;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W - SPEED_W - HELD_W){1'b0}}, rsp_res_ff.entries_held,
                        rsp_res_ff.median_speed};
   assign rsp_tuser  = {rsp_res_ff.status, rsp_res_ff.speed_valid};

`ifndef SYNTHESIS
   // The sequencer leaves idle as soon as a sample is taken.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input still ready after a transaction was accepted");

   // A new result is only presented from the result state.
   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("result presented outside the result state");

   // Invalid results carry a zero speed.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_res_ff.speed_valid) |-> (rsp_res_ff.median_speed == '0))
      else $error("invalid result with non-zero speed");

   // The store never claims more entries than it holds.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff <= DEPTH_C) && (ai_ff <= DEPTH_C))
      else $error("store count beyond depth");
`endif

endmodule

/* design/gwmv_divider.sv */
// Restoring divider that produces one quotient bit per cycle.
// Depends on gwmv_pkg for the dividend and divisor widths.

module gwmv_divider import gwmv_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DIV_W-1:0] divisor,
   output logic             done,
   output logic [DVD_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DVD_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0] rem_ff;
   logic [DVD_W-1:0] quo_ff;
   logic [DIV_W-1:0] div_ff;

   logic [DIV_W:0]   trial;
   logic             fits;
   logic [DIV_W:0]   diff;
   logic [DIV_W-1:0] rem_in;
   logic [DVD_W-1:0] quo_in;

   // One trial subtraction: bring down the next dividend bit.
   always_comb begin
      trial  = {rem_ff, quo_ff[DVD_W-1]};
      fits   = trial >= {1'b0, div_ff};
      diff   = trial - {1'b0, div_ff};
      rem_in = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_in = {quo_ff[DVD_W-2:0], fits};
   end

   // Step control.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder and the shifting dividend that turns into the quotient.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* verif/gated_windowed_median_velocity_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the gated windowed median velocity block.
// It predicts every result from its own copy of the state. It depends on gwmv_pkg and the top level.

module gated_windowed_median_velocity_tb;
   import gwmv_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int STALL_CYCLES = 3000;
   localparam int DRAIN_CYCLES = 400;

   // One input transaction. The last field is in the lowest bits.
   typedef struct packed {
      logic [TIME_W-1:0]        now_time;
      logic [TIME_W-1:0]        sample_time;
      logic signed [HEAD_W-1:0] heading_sin;
      logic signed [HEAD_W-1:0] heading_cos;
      logic signed [POS_W-1:0]  point_y;
      logic signed [POS_W-1:0]  point_x;
   } sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Stimulus and expected results.
   sample_type pending_samples[$];
   result_type expected_medians[$];
   sample_type offered;
   int         idle_pct = 15;
   logic       stall_request = 1'b0;
   int         stall_left = 0;
   int         cycle_count = 0;

   // Predicted state of the block.
   logic signed [POS_W-1:0] prev_x = '0;
   logic signed [POS_W-1:0] prev_y = '0;
   logic [TIME_W-1:0]       prev_time = '0;
   int                      store_speed[STORE_DEPTH_DEF];
   logic [TIME_W-1:0]       store_stamp[STORE_DEPTH_DEF];
   int                      store_held = 0;
   logic [GAP_W-1:0]        cfg_gap = MAX_GAP_RST;
   logic [GAP_W-1:0]        cfg_window = AGE_WINDOW_RST;
   int                      cfg_low = int'(SPEED_LOW_RST);
   int                      cfg_high = int'(SPEED_HIGH_RST);

   // Generator track: the point and time most recently queued.
   int                gen_x = 0;
   int                gen_y = 0;
   logic [TIME_W-1:0] gen_t = '0;

   // Run statistics.
   int errors = 0;
   int samples_queued = 0;
   int samples_taken = 0;
   int results_seen = 0;
   int medians_ok = 0;
   int gaps_bad = 0;
   int speeds_rejected = 0;
   int settings_used = 0;

   gated_windowed_median_velocity u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Clock with a 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Works out the result of one accepted sample and updates the predicted state.
   task automatic predict_median(input sample_type s);
      result_type        r;
      logic [TIME_W-1:0] elapsed;
      longint            dx, dy, num, mag, q;
      int                gap, spd, age, med, i, j, k, v;
      int                ranked[STORE_DEPTH_DEF];
      elapsed = s.sample_time - prev_time;
      gap = $signed(elapsed);
      dx = longint'(s.point_x) - longint'(prev_x);
      dy = longint'(s.point_y) - longint'(prev_y);
      prev_x = s.point_x;
      prev_y = s.point_y;
      prev_time = s.sample_time;
      r = '0;
      if (gap <= 0 || gap > int'(cfg_gap)) begin
         r.status = STAT_GAP;
      end else begin
         // Speed along the heading, truncated toward zero, then saturated.
         num = (dx * longint'(s.heading_cos) + dy * longint'(s.heading_sin)) * 1000;
         mag = (num < 0) ? -num : num;
         q = mag / (longint'(gap) << FRAC_W);
         if (num < 0) begin
            spd = (q > 131072) ? -131072 : -int'(q);
         end else begin
            spd = (q > 131071) ? 131071 : int'(q);
         end
         if (spd <= cfg_low || spd >= cfg_high) begin
            store_held = 0;
            r.status = STAT_RANGE;
         end else begin
            // Drop aged entries; a stamp in the future is kept.
            k = 0;
            for (i = 0; i < store_held; i++) begin
               elapsed = s.now_time - store_stamp[i];
               age = $signed(elapsed);
               if (age <= int'(cfg_window)) begin
                  store_speed[k] = store_speed[i];
                  store_stamp[k] = store_stamp[i];
                  k++;
               end
            end
            // A full store loses its oldest entry before the append.
            if (k >= STORE_DEPTH_DEF) begin
               for (i = 1; i < STORE_DEPTH_DEF; i++) begin
                  store_speed[i-1] = store_speed[i];
                  store_stamp[i-1] = store_stamp[i];
               end
               k = STORE_DEPTH_DEF - 1;
            end
            store_speed[k] = spd;
            store_stamp[k] = s.sample_time;
            store_held = k + 1;
            // Rank the held speeds and take the middle one or the floored mean of the pair.
            for (i = 0; i < store_held; i++) begin
               v = store_speed[i];
               j = i;
               while (j > 0 && ranked[j-1] > v) begin
                  ranked[j] = ranked[j-1];
                  j--;
               end
               ranked[j] = v;
            end
            if (store_held % 2 == 1) begin
               med = ranked[store_held/2];
            end else begin
               med = (ranked[store_held/2-1] + ranked[store_held/2]) >>> 1;
            end
            r.median_speed = SPEED_W'(med);
            r.speed_valid = 1'b1;
            r.status = STAT_OK;
         end
      end
      r.entries_held = HELD_W'(store_held);
      expected_medians = {expected_medians, r};
   endtask

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at result %0d: %s", results_seen, msg);
      errors++;
   endtask

   // Compares one result transaction with the oldest expected result.
   task automatic check_median(input logic [RSP_W-1:0] data, input logic [RSP_USER_W-1:0] user);
      result_type want;
      result_type got;
      results_seen++;
      got.median_speed = data[SPEED_W-1:0];
      got.entries_held = data[SPEED_W +: HELD_W];
      got.speed_valid = user[0];
      got.status = user[1 +: STATUS_W];
      if (expected_medians.size() == 0) begin
         report_mismatch($sformatf("result with none expected, median %0d status %0d",
                                   got.median_speed, got.status));
      end else begin
         want = expected_medians.pop_front();
         if (got.median_speed !== want.median_speed)
            report_mismatch($sformatf("median_speed %0d, expected %0d",
                                      got.median_speed, want.median_speed));
         if (got.speed_valid !== want.speed_valid)
            report_mismatch($sformatf("speed_valid %0d, expected %0d",
                                      got.speed_valid, want.speed_valid));
         if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
         if (got.entries_held !== want.entries_held)
            report_mismatch($sformatf("entries_held %0d, expected %0d",
                                      got.entries_held, want.entries_held));
         if (want.status == STAT_OK) medians_ok++;
         else if (want.status == STAT_GAP) gaps_bad++;
         else speeds_rejected++;
      end
   endtask

   // Input driver: predicts each accepted transaction, then offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_median(offered);
            samples_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
               offered = pending_samples.pop_front();
               req_tdata <= offered;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted transaction and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_median(rsp_tdata, rsp_tuser);
         rsp_tready <= (stall_left == 0) && ($urandom_range(99) >= idle_pct);
      end
   end

   // Long receiver hold-off, counted here so that the sender keeps offering meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_request) begin
         stall_left <= STALL_CYCLES;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_medians.size());
         $display("FAIL gated_windowed_median_velocity");
         $finish;
      end
   end

   // Queues one sample and moves the generator track to it.
   task automatic add_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] hc, input logic [31:0] hs,
                            input logic [31:0] st, input logic [31:0] now);
      sample_type s;
      s.point_x = px[POS_W-1:0];
      s.point_y = py[POS_W-1:0];
      s.heading_cos = hc[HEAD_W-1:0];
      s.heading_sin = hs[HEAD_W-1:0];
      s.sample_time = st;
      s.now_time = now;
      gen_x = s.point_x;
      gen_y = s.point_y;
      gen_t = st;
      pending_samples = {pending_samples, s};
      samples_queued++;
   endtask

   // Cosine of one of eight headings 45 degrees apart, in Q1.14.
   function automatic longint heading_q14(input int dir);
      case (dir)
         0: heading_q14 = 16384;
         1: heading_q14 = 11585;
         2: heading_q14 = 0;
         3: heading_q14 = -11585;
         4: heading_q14 = -16384;
         5: heading_q14 = -11585;
         6: heading_q14 = 0;
         default: heading_q14 = 11585;
      endcase
   endfunction

   // Mostly a plausible track with random content, with noise and broken gaps mixed in.
   task automatic add_random(input int count);
      int                n, pick, dt, v, lo, hi, dir, jitter;
      longint            along, c, sn, nx, ny;
      logic [TIME_W-1:0] st, now;
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            add_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
         end else begin
            // Time gap: mostly short, sometimes at the limit, sometimes invalid.
            if (pick < 14) begin
               case ($urandom_range(2))
                  0: dt = 0;
                  1: dt = -int'($urandom_range(5000, 1));
                  default: dt = int'(cfg_gap) + int'($urandom_range(100, 1));
               endcase
            end else if (pick < 17) begin
               dt = int'(cfg_gap);
            end else begin
               dt = int'($urandom_range((cfg_gap < 40) ? cfg_gap : 40, 1));
            end
            // Target speed: mostly inside the bounds, sometimes beyond them.
            lo = cfg_low + 1;
            hi = cfg_high - 1;
            if (lo < -131071) lo = -131071;
            if (hi > 131070) hi = 131070;
            if (lo > hi) begin
               lo = -131071;
               hi = 131070;
            end
            if ($urandom_range(99) < 8) begin
               v = $urandom_range(1) ? cfg_high + int'($urandom_range(2000))
                                     : cfg_low - int'($urandom_range(2000));
            end else begin
               v = lo + int'($urandom_range(hi - lo));
            end
            dir = $urandom_range(7);
            c = heading_q14(dir);
            sn = heading_q14((dir + 6) % 8);
            along = longint'(v) * ((dt > 0) ? dt : 10) / 1000;
            jitter = ($urandom_range(99) < 30) ? int'($urandom_range(2)) - 1 : 0;
            nx = gen_x + along * c / 16384 + jitter;
            ny = gen_y + along * sn / 16384;
            st = gen_t + 32'(dt);
            // Current time: usually just after the sample, sometimes ageing the store.
            pick = $urandom_range(99);
            if (pick < 6) now = st + cfg_window + $urandom_range(3000, 1);
            else if (pick < 9) now = st + cfg_window;
            else if (pick < 12) now = st - $urandom_range(5000, 1);
            else now = st + $urandom_range(20);
            add_point(32'(nx), 32'(ny), 32'(c), 32'(sn), st, now);
         end
      end
   endtask

   // Waits until every queued sample has been taken and every result checked.
   task automatic wait_drained();
      @(posedge clock);
      while (pending_samples.size() != 0 || req_tvalid || samples_taken != samples_queued
             || expected_medians.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_GAP:    cfg_gap = value[GAP_W-1:0];
         CSR_SPEED_LOW:  cfg_low = int'($signed(value));
         CSR_SPEED_HIGH: cfg_high = int'($signed(value));
         CSR_AGE_WINDOW: cfg_window = value[GAP_W-1:0];
         default: ;
      endcase
   endtask

   // Writes all four registers back to back; valid stays high between them.
   task automatic write_settings(input logic [GAP_W-1:0] gap, input int low, input int high,
                                 input logic [GAP_W-1:0] window);
      write_reg(CSR_MAX_GAP, CSR_DATA_W'(gap));
      write_reg(CSR_SPEED_LOW, CSR_DATA_W'(low));
      write_reg(CSR_SPEED_HIGH, CSR_DATA_W'(high));
      write_reg(CSR_AGE_WINDOW, CSR_DATA_W'(window));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   // Stimulus sequence.
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed samples under the reset settings.
      add_point(8388607, -8388608, 16384, -16384, 0, 0);            // zero gap
      add_point(-8388608, 8388607, -32768, 32767, 32'hFFFF_FFFF, 0); // negative gap
      add_point(0, 0, 16384, 0, 999, 999);          // gap at the limit, speed saturates high
      add_point(0, 0, 16384, 0, 2000, 2000);        // gap one past the limit
      add_point(-100000, 0, 16384, 0, 2001, 2001);  // saturates low
      add_point(-100200, 0, 16384, 0, 2011, 2011);  // exactly on the low bound
      add_point(-99800, 0, 16384, 0, 2021, 2021);   // exactly on the high bound
      add_point(-119799, 0, 16384, 0, 3021, 3021);  // just inside the low bound
      add_point(-119400, 0, 16384, 0, 3031, 3031);
      add_point(-119407, 0, 16384, 0, 3034, 3034);  // negative quotient truncated
      add_point(-119407, 50, 0, 16384, 3044, 3044); // along y only
      add_point(-119407, 51, 0, 16384, 3045, 100);  // stamps lie in the future
      add_point(-119407, 52, 0, 16384, 3046, 3545); // ageing, one entry exactly at the window
      add_point(-119410, 52, 16384, 0, 3047, 3047);
      add_point(-119413, 52, 16384, 0, 4047, 3100);
      add_point(-119414, 52, 16384, 0, 4048, 3100);
      add_point(-119416, 52, 16384, 0, 4049, 3100); // even count, odd negative pair sum
      add_point(-119418, 52, 32767, -32768, 4050, 3100); // heading outside unit range
      add_point(-119418, 52, 16384, 0, 32'hFFFF_FFF0, 3100);  // bad gap across the wrap
      add_point(-119418, 52, 16384, 0, 5, 5);                 // good gap across the wrap
      add_point(-119418, 52, 0, 0, 6, 32'hFFFF_FFFF);         // zero heading
      wait_drained();

      // Ordinary settings with no idling on either side.
      write_settings(16'd600, -30000, 60000, 16'd2000);
      idle_pct <= 0;
      add_random(120);
      wait_drained();

      // Widest settings; the store fills, and the receiver holds off for a long stretch.
      write_settings(16'hFFFF, -131072, 131071, 16'hFFFF);
      idle_pct <= 15;
      add_random(110);
      stall_request <= 1'b1;
      @(posedge clock);
      stall_request <= 1'b0;
      wait_drained();

      // Narrowest settings, with the sample time wrapping.
      write_settings(16'd1, -50, 50, 16'd0);
      add_point(gen_x, gen_y, 16384, 0, 32'hFFFF_FFE0, 32'hFFFF_FFE0);
      add_random(70);
      wait_drained();

      // Bounds crossed over, so that every good gap is rejected.
      write_settings(16'd40, 131071, -131072, 16'd300);
      add_random(25);
      wait_drained();

      // Back to the reset values.
      write_settings(MAX_GAP_RST, int'(SPEED_LOW_RST), int'(SPEED_HIGH_RST), AGE_WINDOW_RST);
      add_random(100);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d samples under %0d register settings plus reset,",
               samples_taken, settings_used);
      $display("with a %0d-cycle stall; checked %0d medians, %0d bad gaps, %0d rejected speeds.",
               STALL_CYCLES, medians_ok, gaps_bad, speeds_rejected);
      if (errors == 0) begin
         $display("PASS gated_windowed_median_velocity");
      end else begin
         $display("FAIL gated_windowed_median_velocity");
      end
      $finish;
   end

endmodule

/* files.f */
design/gwmv_pkg.sv
design/gwmv_divider.sv
design/gated_windowed_median_velocity.sv
verif/gated_windowed_median_velocity_tb.sv
